// ===== hw/rtl/pai_pkg.sv =====
// Shared constants, types and codes of the piecewise affine inverse block.
package pai_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int PT_W   = 32;
    localparam int WT_W   = 32;
    localparam int TGT_W  = 48;
    localparam int FRAC_W = 16;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam int ENT_W  = PT_W + WT_W;
    localparam int SUMW_W = WT_W + CNT_W;
    localparam int PROD_W = WT_W + PT_W + 1;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int REM_W  = SUMW_W + 1;
    localparam int DCNT_W = $clog2(ACC_W + 1);

    localparam int PADDR_W = 3;
    localparam logic REG_SLOPE_K = 1'b0;
    localparam logic [31:0] SLOPE_K_RESET = 32'd65536;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD, S_INS_RD, S_INS_CMP, S_START, S_BIS, S_TGET,
        S_EVAL_K, S_SCAN, S_DIV_SET, S_DIV, S_SAT, S_FIN
    } t_state;

    typedef enum logic [1:0] {M_BIS, M_CHK0, M_CHKN, M_SUM} t_mode;

    typedef struct packed {
        logic [WT_W-1:0]        w;
        logic signed [PT_W-1:0] b;
    } t_entry;

endpackage

// ===== hw/rtl/pai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/piecewise_affine_inverse.sv =====
// Piecewise affine inverse: solves k*t + sum w*min(t,b) = a for t, one row at a time.
// Pairs arrive one per request and are insertion-sorted into a 64-entry pair memory as they
// arrive (stable: equal breakpoints keep arrival order) while s_tready is held low; pairs
// beyond the memory depth are dropped. The request with tlast carries the target and starts
// the solve: a bisection and up to two end checks each evaluate f by a scan over the n stored
// pairs through one 33x32 multiplier (at most ceil(log2 n)+2 scans), one more scan forms the
// partial sums, and a restoring divider then forms the quotient. One result leaves per row on
// m_tdata/m_tuser; the next row is accepted once the result is registered. The pair memory
// needs no clearing.
module piecewise_affine_inverse (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // breakpoint [31:0], weight [63:32], target [111:64]
    input  logic [111:0]                       s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // value [31:0]
    output logic [31:0]                        m_tdata,
    // status [1:0]
    output logic [1:0]                         m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pai_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int AW = pai_pkg::ADDR_W;
    localparam int CW = pai_pkg::CNT_W;
    localparam int XW = pai_pkg::ACC_W;
    localparam int SW = pai_pkg::SUMW_W;

    pai_pkg::t_state r_state, n_state;
    pai_pkg::t_mode  r_mode, n_mode;

    logic [31:0]  r_k;
    logic [CW-1:0] r_cnt, n_cnt, r_n, n_n, r_j, n_j, r_i, n_i, r_ridx, n_ridx;
    logic [CW-1:0] r_ylow, n_ylow, r_yup, n_yup, r_mid, n_mid;
    logic          r_last, n_last, r_rv, n_rv, r_pv, n_pv, r_pin, n_pin, r_case2, n_case2;
    logic          r_neg, n_neg, r_ovalid, n_ovalid;
    logic [pai_pkg::DCNT_W-1:0] r_dcnt, n_dcnt;

    pai_pkg::t_entry r_new, n_new;
    logic [pai_pkg::TGT_W-1:0]         r_a, n_a;
    logic [SW-1:0]                     r_sum_w, n_sum_w, r_pc, n_pc, r_den, n_den;
    logic [pai_pkg::WT_W-1:0]          r_pw, n_pw;
    logic signed [pai_pkg::PT_W-1:0]   r_t, n_t;
    logic signed [pai_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [XW-1:0]              r_acc, n_acc, r_pwb, n_pwb, r_num, n_num;
    logic [XW-1:0]                     r_mag, n_mag, r_q, n_q;
    logic [pai_pkg::REM_W-1:0]         r_rem, n_rem;
    logic [pai_pkg::VAL_W-1:0]         r_res, n_res, r_oval, n_oval;
    logic [pai_pkg::STAT_W-1:0]        r_rst, n_rst, r_ost, n_ost;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    pai_pkg::t_entry         ram_wdata, rd;
    logic [pai_pkg::ENT_W-1:0] ram_rdata;

    logic [pai_pkg::WT_W-1:0]        mul_w;
    logic signed [pai_pkg::PT_W-1:0] mul_m;
    logic signed [pai_pkg::PROD_W-1:0] mul_p;
    logic signed [XW-1:0] aq_ext, prod_ext;
    logic [pai_pkg::REM_W-1:0] rem_sh;
    logic [XW-1:0] lim;
    logic ins_done, cfg_wr, s_acc;

    pai_ram #(.WIDTH(pai_pkg::ENT_W), .DEPTH(pai_pkg::MAX_ENTRIES)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = pai_pkg::t_entry'(ram_rdata);
    assign mul_p    = $signed({1'b0, mul_w}) * mul_m;
    assign aq_ext   = {{(XW - pai_pkg::TGT_W - pai_pkg::FRAC_W){r_a[pai_pkg::TGT_W-1]}},
                       r_a, {pai_pkg::FRAC_W{1'b0}}};
    assign prod_ext = {{(XW - pai_pkg::PROD_W){r_prod[pai_pkg::PROD_W-1]}}, r_prod};
    assign rem_sh   = {r_rem[pai_pkg::REM_W-2:0], r_mag[XW-1]};
    assign lim      = r_neg ? XW'(33'h0_8000_0000) : XW'(33'h0_7FFF_FFFF);

    assign cfg_wr = psel & penable & pwrite & (paddr[2] == pai_pkg::REG_SLOPE_K);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pai_pkg::REG_SLOPE_K) ? r_k : 32'd0;

    assign s_tready = (r_state == pai_pkg::S_LOAD);
    assign s_acc    = s_tvalid & s_tready;
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_oval;
    assign m_tuser  = r_ost;

    always_comb begin
        n_state = r_state;  n_mode = r_mode;  n_cnt = r_cnt;  n_n = r_n;  n_j = r_j;
        n_i = r_i;  n_ridx = r_ridx;  n_ylow = r_ylow;  n_yup = r_yup;  n_mid = r_mid;
        n_last = r_last;  n_rv = r_rv;  n_pv = r_pv;  n_pin = r_pin;  n_case2 = r_case2;
        n_neg = r_neg;  n_dcnt = r_dcnt;  n_new = r_new;  n_a = r_a;  n_sum_w = r_sum_w;
        n_pc = r_pc;  n_den = r_den;  n_pw = r_pw;  n_t = r_t;  n_prod = r_prod;
        n_acc = r_acc;  n_pwb = r_pwb;  n_num = r_num;  n_mag = r_mag;  n_q = r_q;
        n_rem = r_rem;  n_res = r_res;  n_rst = r_rst;  n_oval = r_oval;  n_ost = r_ost;
        n_ovalid = r_ovalid & ~m_tready;
        ram_we = 1'b0;  ram_waddr = r_j[AW-1:0];  ram_wdata = r_new;  ram_raddr = '0;
        mul_w = rd.w;
        mul_m = (r_mode == pai_pkg::M_SUM) ? rd.b : ((r_t < rd.b) ? r_t : rd.b);
        ins_done = 1'b0;

        case (r_state)
            pai_pkg::S_LOAD: begin
                if (s_acc) begin
                    n_new  = pai_pkg::t_entry'(s_tdata[63:0]);
                    n_a    = s_tdata[111:64];
                    n_last = s_tlast;
                    if (r_cnt < CW'(pai_pkg::MAX_ENTRIES)) begin
                        n_j     = r_cnt;
                        n_state = pai_pkg::S_INS_RD;
                    end else if (s_tlast) begin
                        n_state = pai_pkg::S_START;
                    end
                end
            end
            pai_pkg::S_INS_RD: begin
                if (r_j == '0) begin
                    ram_we   = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    ram_raddr = AW'(r_j - 1'b1);
                    n_state   = pai_pkg::S_INS_CMP;
                end
            end
            pai_pkg::S_INS_CMP: begin
                ram_we = 1'b1;
                // shift the larger entry up one place, else write the new pair here
                if (rd.b > r_new.b) begin
                    ram_wdata = rd;
                    n_j       = r_j - 1'b1;
                    n_state   = pai_pkg::S_INS_RD;
                end else begin
                    ins_done = 1'b1;
                end
            end
            pai_pkg::S_START: begin
                n_n     = r_cnt;
                n_cnt   = '0;
                n_ylow  = CW'(1);
                n_yup   = r_cnt;
                n_state = pai_pkg::S_BIS;
            end
            pai_pkg::S_BIS: begin
                if (r_yup > r_ylow + CW'(1)) begin
                    n_mid     = r_ylow + ((r_yup - r_ylow) >> 1);
                    ram_raddr = AW'(n_mid - 1'b1);
                    n_mode    = pai_pkg::M_BIS;
                    n_state   = pai_pkg::S_TGET;
                end else if (r_ylow == CW'(1)) begin
                    ram_raddr = '0;
                    n_mode    = pai_pkg::M_CHK0;
                    n_state   = pai_pkg::S_TGET;
                end else if (r_yup == r_n) begin
                    ram_raddr = AW'(r_n - 1'b1);
                    n_mode    = pai_pkg::M_CHKN;
                    n_state   = pai_pkg::S_TGET;
                end else begin
                    n_mode  = pai_pkg::M_SUM;
                    n_case2 = 1'b0;
                    n_state = pai_pkg::S_EVAL_K;
                end
            end
            pai_pkg::S_TGET: begin
                n_t     = rd.b;
                n_state = pai_pkg::S_EVAL_K;
            end
            pai_pkg::S_EVAL_K: begin
                mul_w   = r_k;
                mul_m   = r_t;
                n_prod  = mul_p;
                n_pv    = (r_mode != pai_pkg::M_SUM);
                n_pin   = 1'b0;
                n_rv    = 1'b0;
                n_i     = '0;
                n_acc   = '0;
                n_pwb   = '0;
                n_pc    = '0;
                n_state = pai_pkg::S_SCAN;
            end
            pai_pkg::S_SCAN: begin
                if (r_i < r_n) begin
                    ram_raddr = r_i[AW-1:0];
                    n_ridx    = r_i;
                    n_i       = r_i + 1'b1;
                    n_rv      = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                n_pv = r_rv;
                if (r_rv) begin
                    n_prod = mul_p;
                    n_pw   = rd.w;
                    n_pin  = (r_ridx < r_ylow);
                end
                if (r_pv) begin
                    n_acc = r_acc + prod_ext;
                    if (r_pin) begin
                        n_pwb = r_pwb + prod_ext;
                        n_pc  = r_pc + SW'(r_pw);
                    end
                end
                if ((r_i == r_n) && !r_rv && !r_pv) begin
                    case (r_mode)
                        pai_pkg::M_BIS: begin
                            n_state = pai_pkg::S_BIS;
                            if (r_acc == aq_ext) begin
                                n_ylow = r_mid;
                                n_yup  = r_mid;
                            end else if (r_acc > aq_ext) begin
                                n_yup = r_mid;
                            end else begin
                                n_ylow = r_mid + 1'b1;
                            end
                        end
                        pai_pkg::M_CHK0: begin
                            if (r_acc >= aq_ext) begin
                                n_num   = aq_ext;
                                n_den   = SW'(r_k) + r_sum_w;
                                n_state = pai_pkg::S_DIV_SET;
                            end else if (r_yup == r_n) begin
                                ram_raddr = AW'(r_n - 1'b1);
                                n_mode    = pai_pkg::M_CHKN;
                                n_state   = pai_pkg::S_TGET;
                            end else begin
                                n_mode  = pai_pkg::M_SUM;
                                n_case2 = 1'b0;
                                n_state = pai_pkg::S_EVAL_K;
                            end
                        end
                        pai_pkg::M_CHKN: begin
                            n_mode  = pai_pkg::M_SUM;
                            n_case2 = (r_acc <= aq_ext);
                            n_state = pai_pkg::S_EVAL_K;
                        end
                        default: begin
                            if (r_case2) begin
                                n_num = aq_ext - r_acc;
                                n_den = SW'(r_k);
                            end else begin
                                n_num = aq_ext - r_pwb;
                                n_den = SW'(r_k) + r_sum_w - r_pc;
                            end
                            n_state = pai_pkg::S_DIV_SET;
                        end
                    endcase
                end
            end
            pai_pkg::S_DIV_SET: begin
                n_neg  = r_num[XW-1];
                n_mag  = r_num[XW-1] ? XW'(-r_num) : XW'(r_num);
                n_rem  = '0;
                n_q    = '0;
                n_dcnt = pai_pkg::DCNT_W'(XW);
                if (r_den == '0) begin
                    n_res   = '0;
                    n_rst   = pai_pkg::ST_DIV0;
                    n_state = pai_pkg::S_FIN;
                end else begin
                    n_state = pai_pkg::S_DIV;
                end
            end
            pai_pkg::S_DIV: begin
                n_mag  = r_mag << 1;
                n_dcnt = r_dcnt - 1'b1;
                if (rem_sh >= {1'b0, r_den}) begin
                    n_rem = rem_sh - {1'b0, r_den};
                    n_q   = {r_q[XW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_q   = {r_q[XW-2:0], 1'b0};
                end
                if (r_dcnt == pai_pkg::DCNT_W'(1)) begin
                    n_state = pai_pkg::S_SAT;
                end
            end
            pai_pkg::S_SAT: begin
                if (r_q > lim) begin
                    n_res = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_rst = pai_pkg::ST_SAT;
                end else begin
                    n_res = r_neg ? (32'd0 - r_q[31:0]) : r_q[31:0];
                    n_rst = pai_pkg::ST_OK;
                end
                n_state = pai_pkg::S_FIN;
            end
            pai_pkg::S_FIN: begin
                // hold until the output register is free
                if (!r_ovalid || m_tready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_res;
                    n_ost    = r_rst;
                    n_sum_w  = '0;
                    n_state  = pai_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = pai_pkg::S_LOAD;
            end
        endcase

        if (ins_done) begin
            n_cnt   = r_cnt + 1'b1;
            n_sum_w = r_sum_w + SW'(r_new.w);
            n_state = r_last ? pai_pkg::S_START : pai_pkg::S_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pai_pkg::S_LOAD;
            r_mode   <= pai_pkg::M_BIS;
            r_k      <= pai_pkg::SLOPE_K_RESET;
            r_cnt    <= '0;
            r_n      <= '0;
            r_j      <= '0;
            r_i      <= '0;
            r_ylow   <= CW'(1);
            r_yup    <= '0;
            r_mid    <= '0;
            r_last   <= 1'b0;
            r_rv     <= 1'b0;
            r_pv     <= 1'b0;
            r_pin    <= 1'b0;
            r_case2  <= 1'b0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
            r_sum_w  <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            if (cfg_wr) begin
                r_k <= pwdata;
            end
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_j      <= n_j;
            r_i      <= n_i;
            r_ylow   <= n_ylow;
            r_yup    <= n_yup;
            r_mid    <= n_mid;
            r_last   <= n_last;
            r_rv     <= n_rv;
            r_pv     <= n_pv;
            r_pin    <= n_pin;
            r_case2  <= n_case2;
            r_dcnt   <= n_dcnt;
            r_ovalid <= n_ovalid;
            r_sum_w  <= n_sum_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= n_ridx;
        r_neg  <= n_neg;
        r_new  <= n_new;
        r_a    <= n_a;
        r_pc   <= n_pc;
        r_den  <= n_den;
        r_pw   <= n_pw;
        r_t    <= n_t;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_pwb  <= n_pwb;
        r_num  <= n_num;
        r_mag  <= n_mag;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_rst  <= n_rst;
        r_oval <= n_oval;
        r_ost  <= n_ost;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(pai_pkg::MAX_ENTRIES))
        else $error("pair count beyond memory depth");

    a_bis_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pai_pkg::S_BIS) |-> (r_ylow >= CW'(1)) && (r_ylow <= r_yup)
            && (r_yup <= r_n))
        else $error("bisection bounds out of order");

    a_ins_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pai_pkg::S_INS_CMP) |-> (r_j != '0) && (r_j <= r_cnt))
        else $error("insertion index out of range");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == pai_pkg::S_FIN))
        else $error("result raised outside the final state");

endmodule
